// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file mcht_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define MCHT_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define MCHT_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/mcht_pkg.sv =====
`timescale 1ns / 1ps

package mcht_pkg;

  localparam int KEY_W    = 31;
  localparam int CMD_W    = 1;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int POS_MAX  = 15;

  // The key is reduced four bits at a time, most significant digit first.
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = 8;
  localparam int DIG_W    = 3;
  localparam int SHIFT_W  = DIGIT_W * DIGITS;

  localparam int PC_W     = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD,
    OP_FILL_RD,
    OP_FILL_LAT,
    OP_WRITE,
    OP_SET_FULL,
    OP_SCAN_START,
    OP_SCAN,
    OP_SET_SCAN,
    OP_EMIT
  } dp_op_t;

  // Branch conditions of the sequencer.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIGIT_MORE,
    C_FIND,
    C_FULL,
    C_EMPTY,
    C_SCAN_MORE,
    C_OUT_BUSY
  } br_cond_t;

  typedef struct packed {
    dp_op_t          op;
    br_cond_t        cond;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic digit_more;
    logic is_find;
    logic full;
    logic empty;
    logic scan_more;
  } dp_flags_t;

endpackage

// ===== rtl/mcht_if.sv =====
`timescale 1ns / 1ps

interface mcht_in_if
  import mcht_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface mcht_out_if
  import mcht_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

// ===== rtl/mcht_seq.sv =====
`timescale 1ns / 1ps

module mcht_seq
  import mcht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_flags_t flags,
  output dp_op_t    op
);

  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_MOD      = 4'd1;
  localparam logic [PC_W-1:0] S_FILL_RD  = 4'd2;
  localparam logic [PC_W-1:0] S_FILL_LAT = 4'd3;
  localparam logic [PC_W-1:0] S_INS      = 4'd4;
  localparam logic [PC_W-1:0] S_WRITE    = 4'd5;
  localparam logic [PC_W-1:0] S_FULL     = 4'd6;
  localparam logic [PC_W-1:0] S_SCAN0    = 4'd7;
  localparam logic [PC_W-1:0] S_SCAN     = 4'd8;
  localparam logic [PC_W-1:0] S_SCAN_END = 4'd9;
  localparam logic [PC_W-1:0] S_OUT      = 4'd10;
  localparam logic [PC_W-1:0] S_BACK     = 4'd11;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctl_word_t       cw;
  logic            take;

  // Microprogram: one control word per step.
  always_comb begin
    case (pc_r)
      S_IDLE:     cw = '{OP_LOAD,       C_NO_INPUT,   S_IDLE};
      S_MOD:      cw = '{OP_MOD,        C_DIGIT_MORE, S_MOD};
      S_FILL_RD:  cw = '{OP_FILL_RD,    C_NEVER,      S_IDLE};
      S_FILL_LAT: cw = '{OP_FILL_LAT,   C_FIND,       S_SCAN0};
      S_INS:      cw = '{OP_NONE,       C_FULL,       S_FULL};
      S_WRITE:    cw = '{OP_WRITE,      C_ALWAYS,     S_OUT};
      S_FULL:     cw = '{OP_SET_FULL,   C_ALWAYS,     S_OUT};
      S_SCAN0:    cw = '{OP_SCAN_START, C_EMPTY,      S_SCAN_END};
      S_SCAN:     cw = '{OP_SCAN,       C_SCAN_MORE,  S_SCAN};
      S_SCAN_END: cw = '{OP_SET_SCAN,   C_ALWAYS,     S_OUT};
      S_OUT:      cw = '{OP_EMIT,       C_OUT_BUSY,   S_OUT};
      S_BACK:     cw = '{OP_NONE,       C_ALWAYS,     S_IDLE};
      default:    cw = '{OP_NONE,       C_ALWAYS,     S_IDLE};
    endcase
  end

  always_comb begin
    case (cw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_INPUT:   take = !flags.in_valid;
      C_DIGIT_MORE: take = flags.digit_more;
      C_FIND:       take = flags.is_find;
      C_FULL:       take = flags.full;
      C_EMPTY:      take = flags.empty;
      C_SCAN_MORE:  take = flags.scan_more;
      C_OUT_BUSY:   take = !flags.out_free;
      default:      take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = cw.op;

endmodule

// ===== rtl/mcht_dp.sv =====
`timescale 1ns / 1ps

module mcht_dp
  import mcht_pkg::*;
#(
  parameter int BUCKETS = 10,
  parameter int DEPTH   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_op_t              op,
  input  logic                in_valid,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [POS_W-1:0]    out_position,
  output dp_flags_t           flags
);

  localparam int BW      = $clog2(BUCKETS);
  localparam int FW      = $clog2(DEPTH + 1);
  localparam int SW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRIES = BUCKETS * DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int MW      = BW + DIGIT_W;

  localparam logic [MW-1:0] M1 = MW'(BUCKETS);
  localparam logic [MW-1:0] M2 = MW'(BUCKETS * 2);
  localparam logic [MW-1:0] M4 = MW'(BUCKETS * 4);
  localparam logic [MW-1:0] M8 = MW'(BUCKETS * 8);

  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [SHIFT_W-1:0]  sh_r;
  logic [DIG_W-1:0]    dig_r;
  logic [BW-1:0]       rem_r;
  logic [AW-1:0]       base_r;
  logic [FW-1:0]       fill_r;
  logic [FW-1:0]       fill_q_r;
  logic                fill_qv_r;
  logic [BUCKETS-1:0]  fill_vld_r;
  logic [KEY_W-1:0]    key_q_r;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       ahead_r;
  logic                hit_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [POS_W-1:0]    res_pos_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_pos_r;

  logic [FW-1:0]      fill_mem [BUCKETS];
  logic [KEY_W-1:0]   key_mem [ENTRIES];

  logic [MW-1:0]   t0, t1, t2, t3, t4;
  logic [BW-1:0]   rem_nxt;
  logic            full, empty, match, last, scan_more, out_free;
  logic [SW-1:0]   slot_first;
  logic [SW-1:0]   rd_slot;
  logic [AW-1:0]   key_raddr;
  logic [AW-1:0]   key_waddr;
  logic [POS_W-1:0] pos_sat;

  // One radix-16 digit of the bucket remainder per step.
  always_comb begin
    t0 = {rem_r, sh_r[SHIFT_W-1 -: DIGIT_W]};
    t1 = (t0 >= M8) ? t0 - M8 : t0;
    t2 = (t1 >= M4) ? t1 - M4 : t1;
    t3 = (t2 >= M2) ? t2 - M2 : t2;
    t4 = (t3 >= M1) ? t3 - M1 : t3;
    rem_nxt = t4[BW-1:0];
  end

  assign full       = (fill_r == FW'(DEPTH));
  assign empty      = (fill_r == '0);
  assign match      = (key_q_r == key_r);
  assign last       = (slot_r == '0);
  assign scan_more  = !match && !last;
  assign out_free   = !out_valid_r || out_ready;
  assign slot_first = empty ? '0 : SW'(fill_r - 1'b1);
  assign pos_sat    = (32'(ahead_r) > 32'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(ahead_r);

  always_comb begin
    case (op)
      OP_SCAN_START: rd_slot = slot_first;
      OP_SCAN:       rd_slot = scan_more ? slot_r - 1'b1 : slot_r;
      default:       rd_slot = '0;
    endcase
  end

  assign key_raddr = base_r + AW'(rd_slot);
  assign key_waddr = base_r + AW'(fill_r);

  always_ff @(posedge clk) begin
    if (op == OP_WRITE) begin
      key_mem[key_waddr] <= key_r;
    end
    key_q_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_WRITE) begin
      fill_mem[rem_r] <= FW'(fill_r + 1'b1);
    end
    fill_q_r <= fill_mem[rem_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r  <= '0;
      fill_qv_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_qv_r <= fill_vld_r[rem_r];
      if (op == OP_WRITE) begin
        fill_vld_r[rem_r] <= 1'b1;
      end
      if (op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          cmd_r <= in_cmd;
          key_r <= in_key;
          sh_r  <= SHIFT_W'(in_key);
          dig_r <= '0;
          rem_r <= '0;
        end
      end
      OP_MOD: begin
        rem_r <= rem_nxt;
        sh_r  <= sh_r << DIGIT_W;
        dig_r <= dig_r + 1'b1;
      end
      OP_FILL_RD: begin
        base_r <= AW'(rem_r) * AW'(DEPTH);
      end
      OP_FILL_LAT: begin
        fill_r <= fill_qv_r ? fill_q_r : '0;
      end
      OP_WRITE: begin
        res_status_r <= ST_INSERTED;
        res_pos_r    <= '0;
      end
      OP_SET_FULL: begin
        res_status_r <= ST_FULL;
        res_pos_r    <= '0;
      end
      OP_SCAN_START: begin
        slot_r  <= slot_first;
        ahead_r <= '0;
        hit_r   <= 1'b0;
      end
      OP_SCAN: begin
        if (match) begin
          hit_r <= 1'b1;
        end else if (!last) begin
          slot_r  <= slot_r - 1'b1;
          ahead_r <= ahead_r + 1'b1;
        end
      end
      OP_SET_SCAN: begin
        res_status_r <= hit_r ? ST_FOUND : ST_MISSING;
        res_pos_r    <= hit_r ? pos_sat : '0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_pos_r    <= res_pos_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready     = (op == OP_LOAD);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;

  assign flags.in_valid   = in_valid;
  assign flags.out_free   = out_free;
  assign flags.digit_more = (dig_r != DIG_W'(DIGITS - 1));
  assign flags.is_find    = (cmd_r == CMD_FIND);
  assign flags.full       = full;
  assign flags.empty      = empty;
  assign flags.scan_more  = scan_more;

endmodule

// ===== rtl/modulo_chained_hash_table_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    cmd (1 bit), key (31 bits)
// out_ch    out        valid/ready    status (2 bits), position (4 bits)
//
// One item is handled at a time. Eight radix-16 remainder steps pick the bucket;
// a find then compares up to DEPTH bucket entries, one key-memory read each.
// Reset (rst_n low, synchronous) clears the bucket valid bits, the step counter
// and the output valid; key storage is not cleared and needs no clearing pass.
// A stalled result holds the sequencer at its output step until out_ch.ready.

module modulo_chained_hash_table_top
  import mcht_pkg::*;
#(
  parameter int BUCKETS = 10,
  parameter int DEPTH   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  mcht_in_if.sink           in_ch,
  mcht_out_if.source        out_ch
);

  // The sequencer steps through its microprogram and issues one datapath
  // operation per cycle; the datapath reports its flags back as branch inputs.
  dp_op_t    op;
  dp_flags_t flags;

  mcht_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  // The datapath holds the key memory, the per-bucket fill counts, the
  // remainder unit and the result register that faces out_ch.
  mcht_dp #(
    .BUCKETS (BUCKETS),
    .DEPTH   (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_valid     (in_ch.valid),
    .in_cmd       (in_ch.cmd),
    .in_key       (in_ch.key),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_position (out_ch.position),
    .flags        (flags)
  );

endmodule

// ===== rtl/mcht_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcht_chk
  import mcht_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CMD_W-1:0]    in_cmd,
  input logic [KEY_W-1:0]    in_key,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [POS_W-1:0]    out_position
);

  // An offered item that is not taken stays on the bus unchanged.
  `MCHT_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable({in_cmd, in_key}), "waiting item changed")

  // A result that is not taken keeps its value.
  `MCHT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_position), "stalled result changed")

  // Only a hit carries a nonzero position.
  `MCHT_ASSERT(a_pos_hit, clk, rst_n, out_valid && out_position != '0 |-> out_status == ST_FOUND, "nonzero position without a hit")

  // The block works on one item at a time.
  `MCHT_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "second item taken while busy")

  // Reset leaves no result pending.
  `MCHT_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind modulo_chained_hash_table_top mcht_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_cmd       (in_ch.cmd),
  .in_key       (in_ch.key),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_position (out_ch.position)
);

// ===== sim/tb_modulo_chained_hash_table_top.sv =====
`timescale 1ns / 1ps

// Testbench for the modulo chained hash table.
//
// A driver and a monitor, both clocked always blocks, sit on the two channels.
// The driver takes items from a queue that the stimulus initial block fills
// up front. At every accepted item it runs the table predictor below and
// pushes the expected result. The monitor pops that expectation for every
// accepted result and compares status and position. Both sides idle in random
// bursts, and once in the run the receiver holds off for a long stretch while
// the driver keeps offering, so the block backs up and stalls its input.

module tb_modulo_chained_hash_table_top;
  import mcht_pkg::*;

  localparam int unsigned BUCKETS = 10;
  localparam int unsigned DEPTH   = 16;

  // Finds in a full bucket are the slowest items: hash, up to DEPTH reads,
  // and the output step. Wait a comfortable multiple of that at the end.
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_ITEMS   = 1374;
  localparam int CALM_TAIL      = 120;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } table_result_t;

  logic clk;
  logic rst_n = 1'b0;

  mcht_in_if  in_ch ();
  mcht_out_if out_ch ();

  modulo_chained_hash_table_top #(
    .BUCKETS (BUCKETS),
    .DEPTH   (DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Every input of the block holds a known value before the first edge.
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_INSERT;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
  end

  // Items waiting to be offered, results the block still owes, and the keys
  // the stimulus has inserted so far (used to aim finds at present keys).
  table_op_t     pending_ops[$];
  table_result_t owed_results[$];
  logic [KEY_W-1:0] inserted_keys[$];

  int fail_count     = 0;
  int items_accepted = 0;
  bit calm_tail      = 1'b0;

  // Our own copy of the table. Slot 0 of a bucket is its oldest key.
  logic [KEY_W-1:0] shadow_keys [BUCKETS][DEPTH];
  int unsigned      shadow_fill [BUCKETS] = '{default: 0};

  // Applies one operation to the shadow table and returns what the block
  // must answer. A find walks from the newest key toward the oldest and stops
  // at the first match, so a duplicate reports its newest copy.
  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t res;
    int unsigned   b;
    int unsigned   ahead;
    bit            hit;
    b            = op.key % BUCKETS;
    res.status   = ST_MISSING;
    res.position = '0;
    if (op.cmd == CMD_INSERT) begin
      if (shadow_fill[b] >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_keys[b][shadow_fill[b]] = op.key;
        shadow_fill[b] = shadow_fill[b] + 1;
        res.status = ST_INSERTED;
      end
    end else begin
      hit   = 1'b0;
      ahead = 0;
      while (!hit && ahead < shadow_fill[b]) begin
        if (shadow_keys[b][shadow_fill[b] - 1 - ahead] == op.key) begin
          hit = 1'b1;
        end else begin
          ahead++;
        end
      end
      if (hit) begin
        res.status   = ST_FOUND;
        res.position = (ahead > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(ahead);
      end
    end
    return res;
  endfunction

  // Keys come from several ranges so that both the high bits and the small
  // buckets get exercised.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: begin
        k = KEY_W'($urandom);
      end
      1: begin
        k = KEY_W'($urandom_range(0, 199));
      end
      2: begin
        k = {1'b1, (KEY_W - 1)'($urandom)};
      end
      default: begin
        k = KEY_MAX - KEY_W'($urandom_range(0, 50));
      end
    endcase
    return k;
  endfunction

  task automatic queue_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    table_op_t op;
    op.cmd = cmd;
    op.key = key;
    pending_ops.push_back(op);
    if (cmd == CMD_INSERT) begin
      inserted_keys.push_back(key);
    end
  endtask

  // Driver. An offered item stays on the bus until it is taken; idle bursts
  // only fall between items. The idle rate is rerolled every 64 items so the
  // run has quiet stretches, busy stretches and gap-heavy stretches.
  int gap_left = 0;
  int gap_pct  = 10;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(apply_table_op(pending_ops[0]));
        void'(pending_ops.pop_front());
        items_accepted <= items_accepted + 1;
        if ((items_accepted % 64) == 63) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 35;
          endcase
        end
      end
      if (pending_ops.size() < CALM_TAIL) begin
        calm_tail <= 1'b1;
      end
      if (gap_left > 0 && !calm_tail) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
        gap_left = $urandom_range(1, 15) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= pending_ops[0].cmd;
        in_ch.key   <= pending_ops[0].key;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long back-pressure stretch. It starts once a few hundred items are in and
  // lasts far longer than one item takes, so the block must stop accepting.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Every accepted result is checked against the oldest owed one.
  int stall_left = 0;
  int stall_pct  = 10;

  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status   = out_ch.status;
        got.position = out_ch.position;
        if (owed_results.size() == 0) begin
          $error("result with no item owed: status %0d, position %0d",
                 got.status, got.position);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   want.position, got.position);
            fail_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) begin
          stall_pct = ($urandom_range(0, 1) == 0) ? 0 : 30;
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0 && !calm_tail) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int pick;
    // Directed part. Key zero and the largest key, a find of the newest key,
    // a miss in an empty bucket and a miss in a filled one, a duplicate
    // insert with a find that must see the newest copy, then one bucket
    // filled to the brim, refused once, and searched at its oldest entry.
    queue_op(CMD_INSERT, '0);
    queue_op(CMD_INSERT, KEY_MAX);
    queue_op(CMD_FIND, KEY_MAX);
    queue_op(CMD_FIND, '0);
    queue_op(CMD_FIND, KEY_W'(5));
    queue_op(CMD_FIND, KEY_W'(10));
    queue_op(CMD_INSERT, '0);
    queue_op(CMD_FIND, '0);
    for (int i = 0; i < DEPTH; i++) begin
      queue_op(CMD_INSERT, KEY_W'(3 + 10 * i));
    end
    queue_op(CMD_INSERT, KEY_W'(3 + 10 * DEPTH));
    queue_op(CMD_FIND, KEY_W'(3));

    // Random part. Finds mostly aim at keys already inserted so that hits
    // land at every depth; the rest are inserts, some of them duplicates, and likely misses.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 4) == 0 && inserted_keys.size() > 0) begin
          queue_op(CMD_INSERT, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        end else begin
          queue_op(CMD_INSERT, random_key());
        end
      end else if (pick < 85 && inserted_keys.size() > 0) begin
        queue_op(CMD_FIND, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
      end else begin
        queue_op(CMD_FIND, random_key());
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (pending_ops.size() != 0 || in_ch.valid || owed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS modulo_chained_hash_table_top");
    end else begin
      $display("FAIL modulo_chained_hash_table_top");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAIL modulo_chained_hash_table_top");
    $finish;
  end

endmodule
